// ----- src/bhpq_pkg.sv -----
// Shared constants and codes for the binary heap priority queue.
`timescale 1ns / 1ps

package bhpq_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 9;
    localparam int VAL_W    = 32;
    localparam int KIND_W   = 2;
    localparam int IDX_W    = ADDR_W + 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_PEEK   = 2'd2
    } kind_t;

endpackage

// ----- src/binary_heap_priority_queue_unit.sv -----
// Top level: binary heap priority queue with a shared compare unit and sequencer.
`timescale 1ns / 1ps

//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: kind; tdata: value
//  m_*     | out | m_tvalid/m_tready  | tdata: root_value, entry_count; tuser: flags
//  cfg_*   | in  | cfg_wen            | cfg_wdata: min_order
//
//  Steps: a peek, a refused insert and a remove to or from empty go straight to the
//  result; an insert reads the parent and compares once per level climbed; a remove reads
//  the old last entry, then reads both children and compares each per level descended.
//  Reset clears the count and the mode; the heap store itself is not cleared.
//  s_tready is high only while the sequencer is idle; a result waiting on m_tready
//  holds the sequencer in its final step but the next word is accepted once it moves on.
module binary_heap_priority_queue_unit
    import bhpq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wen,
    input  logic        cfg_wdata,      // [0] min_order
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,        // [31:0] value
    input  logic [1:0]  s_tuser,        // [1:0] kind
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,        // [31:0] root_value, [40:32] entry_count, zero pad
    output logic [2:0]  m_tuser         // [0] is_empty, [1] full_reject, [2] empty_peek_error
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_UP_RD  = 9'b000000010,
        ST_UP_CMP = 9'b000000100,
        ST_RM_RD  = 9'b000001000,
        ST_RM_LD  = 9'b000010000,
        ST_DN_RD  = 9'b000100000,
        ST_DN_CL  = 9'b001000000,
        ST_DN_CR  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic              min_order_reg;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [VAL_W-1:0]  mov_reg, mov_next;
    logic [VAL_W-1:0]  best_val_reg, best_val_next;
    logic [ADDR_W-1:0] best_pos_reg, best_pos_next;
    logic              best_moved_reg, best_moved_next;
    logic              r_ok_reg, r_ok_next;
    logic              reject_reg, reject_next;
    logic              peek_err_reg, peek_err_next;

    // heap store, one write and two registered reads
    logic [VAL_W-1:0]  mem [CAPACITY];
    logic [VAL_W-1:0]  rda_reg, rdb_reg, root_reg;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rda_addr, rdb_addr, wr_addr;
    logic [VAL_W-1:0]  wr_data;

    // output register
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_root_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic [2:0]        out_flags_reg;
    logic              out_load;

    // shared comparator
    logic [VAL_W-1:0]  cmp_a, cmp_b;
    logic              cmp_above;

    logic [IDX_W-1:0]  lc, rc;
    logic [ADDR_W-1:0] parent;
    logic              accept;
    kind_t             kind;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign kind     = kind_t'(s_tuser);

    assign lc     = {1'b0, pos_reg, 1'b1};
    assign rc     = {1'b0, pos_reg, 1'b0} + IDX_W'(2);
    assign parent = (pos_reg - ADDR_W'(1)) >> 1;

    // a ranks nearer the root than b
    always_comb
    begin
        case (state_reg)
            ST_UP_CMP: begin cmp_a = mov_reg; cmp_b = rda_reg;      end
            ST_DN_CL:  begin cmp_a = rda_reg; cmp_b = mov_reg;      end
            ST_DN_CR:  begin cmp_a = rdb_reg; cmp_b = best_val_reg; end
            default:   begin cmp_a = rda_reg; cmp_b = mov_reg;      end
        endcase
        cmp_above = min_order_reg ? ($signed(cmp_a) < $signed(cmp_b))
                                  : ($signed(cmp_a) > $signed(cmp_b));
    end

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        pos_next        = pos_reg;
        mov_next        = mov_reg;
        best_val_next   = best_val_reg;
        best_pos_next   = best_pos_reg;
        best_moved_next = best_moved_reg;
        r_ok_next       = r_ok_reg;
        reject_next     = reject_reg;
        peek_err_next   = peek_err_reg;
        rd_en           = 1'b0;
        rda_addr        = pos_reg;
        rdb_addr        = pos_reg;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = mov_reg;
        out_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    reject_next   = 1'b0;
                    peek_err_next = 1'b0;
                    case (kind)
                        KIND_INSERT:
                        begin
                            if (occ_reg == CNT_W'(CAPACITY))
                            begin
                                reject_next = 1'b1;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                pos_next   = occ_reg[ADDR_W-1:0];
                                mov_next   = s_tdata;
                                occ_next   = occ_reg + CNT_W'(1);
                                state_next = ST_UP_RD;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (occ_reg == '0)
                                state_next = ST_DONE;
                            else
                            begin
                                occ_next   = occ_reg - CNT_W'(1);
                                state_next = (occ_reg == CNT_W'(1)) ? ST_DONE : ST_RM_RD;
                            end
                        end
                        default:
                        begin
                            peek_err_next = (occ_reg == '0);
                            state_next    = ST_DONE;
                        end
                    endcase
                end
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rda_addr   = parent;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                wr_en = 1'b1;
                if (cmp_above)
                begin
                    wr_data    = rda_reg;       // parent moves down
                    pos_next   = parent;
                    state_next = ST_UP_RD;
                end
                else
                    state_next = ST_DONE;
            end
            ST_RM_RD:
            begin
                rd_en      = 1'b1;
                rda_addr   = occ_reg[ADDR_W-1:0];   // old last entry
                state_next = ST_RM_LD;
            end
            ST_RM_LD:
            begin
                mov_next   = rda_reg;
                pos_next   = '0;
                state_next = ST_DN_RD;
            end
            ST_DN_RD:
            begin
                if (lc >= IDX_W'(occ_reg))
                begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rda_addr   = lc[ADDR_W-1:0];
                    rdb_addr   = rc[ADDR_W-1:0];
                    r_ok_next  = (rc < IDX_W'(occ_reg));
                    state_next = ST_DN_CL;
                end
            end
            ST_DN_CL:
            begin
                if (cmp_above)
                begin
                    best_val_next   = rda_reg;
                    best_pos_next   = lc[ADDR_W-1:0];
                    best_moved_next = 1'b1;
                end
                else
                begin
                    best_val_next   = mov_reg;
                    best_pos_next   = pos_reg;
                    best_moved_next = 1'b0;
                end
                state_next = ST_DN_CR;
            end
            ST_DN_CR:
            begin
                wr_en = 1'b1;
                if (r_ok_reg && cmp_above)
                begin
                    wr_data    = rdb_reg;       // right child moves up
                    pos_next   = rc[ADDR_W-1:0];
                    state_next = ST_DN_RD;
                end
                else if (best_moved_reg)
                begin
                    wr_data    = best_val_reg;  // left child moves up
                    pos_next   = best_pos_reg;
                    state_next = ST_DN_RD;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            min_order_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (cfg_wen)
                min_order_reg <= cfg_wdata;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        mov_reg        <= mov_next;
        best_val_reg   <= best_val_next;
        best_pos_reg   <= best_pos_next;
        best_moved_reg <= best_moved_next;
        r_ok_reg       <= r_ok_next;
        reject_reg     <= reject_next;
        peek_err_reg   <= peek_err_next;
        if (out_load)
        begin
            out_root_reg  <= (occ_reg != '0) ? root_reg : '0;
            out_count_reg <= occ_reg;
            out_flags_reg <= {peek_err_reg, reject_reg, (occ_reg == '0)};
        end
    end

    // heap store; root_reg shadows slot 0
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
            if (wr_addr == '0)
                root_reg <= wr_data;
        end
        if (rd_en)
        begin
            rda_reg <= mem[rda_addr];
            rdb_reg <= mem[rdb_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_root_reg};
    assign m_tuser  = out_flags_reg;

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_occ_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(occ_reg))
        else $error("occupancy changed while sifting");

    a_pos_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP_RD || state_reg == ST_UP_CMP || state_reg == ST_DN_RD ||
         state_reg == ST_DN_CL || state_reg == ST_DN_CR) |-> (CNT_W'(pos_reg) < occ_reg))
        else $error("sift position outside live entries");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[40:32] == CNT_W'(CAPACITY)))
        else $error("insert refused with room left");
`endif

endmodule
